/* sv/ipspb_pkg.sv */
package ipspb_pkg;

    localparam int MAX_RECORDS_DEF = 256;
    localparam int DATA_BYTES_DEF  = 65536;

    // "EOF" offset that ends a patch file
    localparam logic [23:0] EOF_MARK = {8'h45, 8'h4F, 8'h46};

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_READ   = 2'd1,
        OP_REWIND = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_FINISHED   = 3'd1,
        ST_BAD_HEADER = 3'd2,
        ST_FULL       = 3'd3,
        ST_IGNORED    = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        PH_HDR0  = 4'd0,
        PH_HDR1  = 4'd1,
        PH_HDR2  = 4'd2,
        PH_HDR3  = 4'd3,
        PH_HDR4  = 4'd4,
        PH_OFS0  = 4'd5,
        PH_OFS1  = 4'd6,
        PH_OFS2  = 4'd7,
        PH_SIZE0 = 4'd8,
        PH_SIZE1 = 4'd9,
        PH_RUN0  = 4'd10,
        PH_RUN1  = 4'd11,
        PH_FILL  = 4'd12,
        PH_DATA  = 4'd13,
        PH_DONE  = 4'd14,
        PH_ERROR = 4'd15
    } phase_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_EXEC,
        C_SCAN,
        C_DATA,
        C_PUSH
    } ctrl_state_t;

    typedef enum logic [1:0] {
        DO_NONE,
        DO_EXEC,
        DO_SCAN,
        DO_DATA
    } dp_op_t;

    typedef enum logic [1:0] {
        SC_MISS,
        SC_NEXT,
        SC_HIT_FILL,
        SC_HIT_DATA
    } scan_t;

    typedef struct packed {
        logic   accept;
        dp_op_t op;
        logic   push;
    } cmd_t;

    typedef struct packed {
        logic  is_read;
        logic  empty;
        scan_t scan;
    } stat_t;

    // "PATCH" header text
    function automatic logic [7:0] header_char(input logic [2:0] pos);
        logic [7:0] c;
        begin
            case (pos)
                3'd0:    c = 8'h50;
                3'd1:    c = 8'h41;
                3'd2:    c = 8'h54;
                3'd3:    c = 8'h43;
                3'd4:    c = 8'h48;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

endpackage

/* sv/ipspb_if.sv */
interface ipspb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  patch_byte;
    logic [23:0] read_address;
    logic [7:0]  original_byte;
    logic        original_present;

    modport source (output valid, operation, patch_byte, read_address, original_byte,
                    original_present, input ready);
    modport sink (input valid, operation, patch_byte, read_address, original_byte,
                  original_present, output ready);
endinterface

interface ipspb_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] result_byte;
    logic       result_present;
    logic       patched;

    modport source (output valid, status, result_byte, result_present, patched,
                    input ready);
    modport sink (input valid, status, result_byte, result_present, patched,
                  output ready);
endinterface

/* sv/ipspb_ctrl.sv */
module ipspb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  ipspb_pkg::stat_t  stat,
    output ipspb_pkg::cmd_t   cmd
);

    ipspb_pkg::ctrl_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ipspb_pkg::C_IDLE:
            begin
                if (in_valid)
                    state_next = ipspb_pkg::C_EXEC;
            end
            ipspb_pkg::C_EXEC:
            begin
                if (stat.is_read && !stat.empty)
                    state_next = ipspb_pkg::C_SCAN;
                else
                    state_next = ipspb_pkg::C_PUSH;
            end
            ipspb_pkg::C_SCAN:
            begin
                unique case (stat.scan)
                    ipspb_pkg::SC_HIT_DATA: state_next = ipspb_pkg::C_DATA;
                    ipspb_pkg::SC_NEXT:     state_next = ipspb_pkg::C_SCAN;
                    default:                state_next = ipspb_pkg::C_PUSH;
                endcase
            end
            ipspb_pkg::C_DATA:
            begin
                state_next = ipspb_pkg::C_PUSH;
            end
            ipspb_pkg::C_PUSH:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ipspb_pkg::C_IDLE;
            end
            default:
            begin
                state_next = ipspb_pkg::C_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.op     = ipspb_pkg::DO_NONE;
        cmd.push   = 1'b0;
        unique case (state_reg)
            ipspb_pkg::C_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ipspb_pkg::C_EXEC: cmd.op = ipspb_pkg::DO_EXEC;
            ipspb_pkg::C_SCAN: cmd.op = ipspb_pkg::DO_SCAN;
            ipspb_pkg::C_DATA: cmd.op = ipspb_pkg::DO_DATA;
            ipspb_pkg::C_PUSH: cmd.push = !out_valid_reg || out_ready;
            default:           cmd.op = ipspb_pkg::DO_NONE;
        endcase
    end

    always_comb
    begin
        if (cmd.push)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ipspb_pkg::C_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* sv/ipspb_dp.sv */
module ipspb_dp #(
    parameter int MAX_RECORDS = ipspb_pkg::MAX_RECORDS_DEF,
    parameter int DATA_BYTES  = ipspb_pkg::DATA_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ipspb_pkg::cmd_t  cmd,
    output ipspb_pkg::stat_t stat,
    input  logic [1:0]       operation,
    input  logic [7:0]       patch_byte,
    input  logic [23:0]      read_address,
    input  logic [7:0]       original_byte,
    input  logic             original_present,
    output logic [2:0]       status,
    output logic [7:0]       result_byte,
    output logic             result_present,
    output logic             patched
);

    localparam int RW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int AW = $clog2(DATA_BYTES);
    localparam int PW = $clog2(DATA_BYTES + 1);
    localparam int SW = ((PW > 16) ? PW : 16) + 1;

    typedef struct packed {
        logic [23:0]   first;
        logic [24:0]   limit;
        logic [AW-1:0] base;
        logic          is_fill;
        logic [7:0]    fill;
    } rec_t;

    // item and result words
    ipspb_pkg::op_t op_reg;
    logic [7:0]  pbyte_reg;
    logic [23:0] addr_reg;
    logic [7:0]  orig_reg;
    logic        origp_reg;
    ipspb_pkg::status_t rstat_reg, rstat_next;
    logic [7:0]  rbyte_reg, rbyte_next;
    logic        rpres_reg, rpres_next;
    logic        rpatch_reg, rpatch_next;
    logic [2:0]  ostat_reg;
    logic [7:0]  obyte_reg;
    logic        opres_reg;
    logic        opatch_reg;

    // parser and table state
    ipspb_pkg::phase_t phase_reg, phase_next;
    logic [23:0]   facc_reg, facc_next;
    logic [15:0]   lacc_reg, lacc_next;
    logic [15:0]   brem_reg, brem_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] wp_reg, wp_next;
    logic [CW-1:0] cursor_reg, cursor_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          start_reg, start_next;

    rec_t          tbl_mem [MAX_RECORDS];
    rec_t          tbl_rd_reg;
    logic [7:0]    store_mem [DATA_BYTES];
    logic [7:0]    store_rd_reg;

    logic          tbl_we;
    rec_t          tbl_wdata;
    logic          st_we;
    ipspb_pkg::status_t ld_status;
    logic [23:0]   f_new;
    logic [15:0]   l_new;
    logic          tbl_full;
    logic          store_full;

    logic [CW-1:0] idx_inc;
    logic [CW-1:0] tbl_raddr;
    logic [AW-1:0] st_raddr;
    logic          covers;
    logic          stop;
    logic          advance;
    ipspb_pkg::scan_t scan;

    // record parser, one patch byte per step
    always_comb
    begin
        phase_next = phase_reg;
        facc_next  = facc_reg;
        lacc_next  = lacc_reg;
        brem_next  = brem_reg;
        count_next = count_reg;
        wp_next    = wp_reg;
        tbl_we     = 1'b0;
        st_we      = 1'b0;
        ld_status  = ipspb_pkg::ST_OK;
        f_new      = {facc_reg[15:0], pbyte_reg};
        l_new      = {lacc_reg[7:0], pbyte_reg};
        tbl_full   = (count_reg >= CW'(MAX_RECORDS));
        store_full = (SW'(wp_reg) + SW'(l_new)) > SW'(DATA_BYTES);
        tbl_wdata.first   = facc_reg;
        tbl_wdata.limit   = {1'b0, facc_reg} + {9'd0, l_new};
        tbl_wdata.base    = wp_reg[AW-1:0];
        tbl_wdata.is_fill = 1'b0;
        tbl_wdata.fill    = pbyte_reg;
        case (phase_reg)
            ipspb_pkg::PH_HDR0, ipspb_pkg::PH_HDR1, ipspb_pkg::PH_HDR2,
            ipspb_pkg::PH_HDR3, ipspb_pkg::PH_HDR4:
            begin
                if (pbyte_reg != ipspb_pkg::header_char(phase_reg[2:0]))
                begin
                    phase_next = ipspb_pkg::PH_ERROR;
                    ld_status  = ipspb_pkg::ST_BAD_HEADER;
                end
                else
                    phase_next = ipspb_pkg::phase_t'(phase_reg + 4'd1);
            end
            ipspb_pkg::PH_OFS0:
            begin
                facc_next  = {16'd0, pbyte_reg};
                phase_next = ipspb_pkg::PH_OFS1;
            end
            ipspb_pkg::PH_OFS1:
            begin
                facc_next  = f_new;
                phase_next = ipspb_pkg::PH_OFS2;
            end
            ipspb_pkg::PH_OFS2:
            begin
                facc_next = f_new;
                if (f_new == ipspb_pkg::EOF_MARK)
                begin
                    phase_next = ipspb_pkg::PH_DONE;
                    ld_status  = ipspb_pkg::ST_FINISHED;
                end
                else
                    phase_next = ipspb_pkg::PH_SIZE0;
            end
            ipspb_pkg::PH_SIZE0, ipspb_pkg::PH_RUN0:
            begin
                lacc_next  = {8'd0, pbyte_reg};
                phase_next = ipspb_pkg::phase_t'(phase_reg + 4'd1);
            end
            ipspb_pkg::PH_SIZE1:
            begin
                lacc_next = l_new;
                if (l_new == 16'd0)
                    phase_next = ipspb_pkg::PH_RUN0;
                else if (tbl_full || store_full)
                begin
                    phase_next = ipspb_pkg::PH_ERROR;
                    ld_status  = ipspb_pkg::ST_FULL;
                end
                else
                begin
                    // entry opens now, becomes visible when count moves
                    tbl_we     = 1'b1;
                    brem_next  = l_new;
                    phase_next = ipspb_pkg::PH_DATA;
                end
            end
            ipspb_pkg::PH_RUN1:
            begin
                lacc_next  = l_new;
                phase_next = ipspb_pkg::PH_FILL;
            end
            ipspb_pkg::PH_FILL:
            begin
                tbl_wdata.limit   = {1'b0, facc_reg} + {9'd0, lacc_reg};
                tbl_wdata.base    = '0;
                tbl_wdata.is_fill = 1'b1;
                if (tbl_full)
                begin
                    phase_next = ipspb_pkg::PH_ERROR;
                    ld_status  = ipspb_pkg::ST_FULL;
                end
                else
                begin
                    tbl_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                    phase_next = ipspb_pkg::PH_OFS0;
                end
            end
            ipspb_pkg::PH_DATA:
            begin
                st_we     = 1'b1;
                wp_next   = wp_reg + PW'(1);
                brem_next = brem_reg - 16'd1;
                if (brem_reg == 16'd1)
                begin
                    count_next = count_reg + CW'(1);
                    phase_next = ipspb_pkg::PH_OFS0;
                end
            end
            default:
            begin
                ld_status = ipspb_pkg::ST_IGNORED;
            end
        endcase
    end

    // scan of one table entry
    always_comb
    begin
        idx_inc = idx_reg + CW'(1);
        covers  = (tbl_rd_reg.first <= addr_reg) && (tbl_rd_reg.limit > {1'b0, addr_reg});
        stop    = !start_reg && (tbl_rd_reg.first > addr_reg);
        advance = (tbl_rd_reg.first == addr_reg)
                  && (tbl_rd_reg.limit == ({1'b0, addr_reg} + 25'd1));
        if (stop)
            scan = ipspb_pkg::SC_MISS;
        else if (covers)
            scan = tbl_rd_reg.is_fill ? ipspb_pkg::SC_HIT_FILL : ipspb_pkg::SC_HIT_DATA;
        else if (idx_inc >= count_reg)
            scan = ipspb_pkg::SC_MISS;
        else
            scan = ipspb_pkg::SC_NEXT;
        tbl_raddr = (cmd.op == ipspb_pkg::DO_EXEC) ? cursor_reg : idx_inc;
        st_raddr  = tbl_rd_reg.base + AW'(addr_reg - tbl_rd_reg.first);
    end

    assign stat.is_read = (op_reg == ipspb_pkg::OP_READ);
    assign stat.empty   = (cursor_reg >= count_reg);
    assign stat.scan    = scan;

    // control state and result word
    always_comb
    begin
        cursor_next = cursor_reg;
        idx_next    = idx_reg;
        start_next  = start_reg;
        rstat_next  = rstat_reg;
        rbyte_next  = rbyte_reg;
        rpres_next  = rpres_reg;
        rpatch_next = rpatch_reg;
        case (cmd.op)
            ipspb_pkg::DO_EXEC:
            begin
                rstat_next  = ipspb_pkg::ST_OK;
                rbyte_next  = 8'd0;
                rpres_next  = 1'b0;
                rpatch_next = 1'b0;
                case (op_reg)
                    ipspb_pkg::OP_LOAD:
                        rstat_next = ld_status;
                    ipspb_pkg::OP_READ:
                    begin
                        idx_next   = cursor_reg;
                        start_next = 1'b1;
                        rbyte_next = origp_reg ? orig_reg : 8'd0;
                        rpres_next = origp_reg;
                    end
                    ipspb_pkg::OP_REWIND:
                        cursor_next = '0;
                    default:
                        rstat_next = ipspb_pkg::ST_IGNORED;
                endcase
            end
            ipspb_pkg::DO_SCAN:
            begin
                start_next = 1'b0;
                idx_next   = idx_inc;
                if (scan == ipspb_pkg::SC_HIT_FILL || scan == ipspb_pkg::SC_HIT_DATA)
                    cursor_next = advance ? idx_inc : idx_reg;
                if (scan == ipspb_pkg::SC_HIT_FILL)
                begin
                    rbyte_next  = tbl_rd_reg.fill;
                    rpres_next  = 1'b1;
                    rpatch_next = 1'b1;
                end
            end
            ipspb_pkg::DO_DATA:
            begin
                rbyte_next  = store_rd_reg;
                rpres_next  = 1'b1;
                rpatch_next = 1'b1;
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ipspb_pkg::PH_HDR0;
            facc_reg   <= '0;
            lacc_reg   <= '0;
            brem_reg   <= '0;
            count_reg  <= '0;
            wp_reg     <= '0;
            cursor_reg <= '0;
            idx_reg    <= '0;
            start_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.op == ipspb_pkg::DO_EXEC && op_reg == ipspb_pkg::OP_LOAD)
            begin
                phase_reg <= phase_next;
                facc_reg  <= facc_next;
                lacc_reg  <= lacc_next;
                brem_reg  <= brem_next;
                count_reg <= count_next;
                wp_reg    <= wp_next;
            end
            cursor_reg <= cursor_next;
            idx_reg    <= idx_next;
            start_reg  <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= ipspb_pkg::op_t'(operation);
            pbyte_reg <= patch_byte;
            addr_reg  <= read_address;
            orig_reg  <= original_byte;
            origp_reg <= original_present;
        end
        rstat_reg  <= rstat_next;
        rbyte_reg  <= rbyte_next;
        rpres_reg  <= rpres_next;
        rpatch_reg <= rpatch_next;
        if (cmd.push)
        begin
            ostat_reg  <= rstat_reg;
            obyte_reg  <= rbyte_reg;
            opres_reg  <= rpres_reg;
            opatch_reg <= rpatch_reg;
        end
    end

    // record table and byte store
    always_ff @(posedge clk)
    begin
        if (cmd.op == ipspb_pkg::DO_EXEC && op_reg == ipspb_pkg::OP_LOAD && tbl_we)
            tbl_mem[count_reg[RW-1:0]] <= tbl_wdata;
        tbl_rd_reg <= tbl_mem[tbl_raddr[RW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == ipspb_pkg::DO_EXEC && op_reg == ipspb_pkg::OP_LOAD && st_we)
            store_mem[wp_reg[AW-1:0]] <= pbyte_reg;
        store_rd_reg <= store_mem[st_raddr];
    end

    assign status         = ostat_reg;
    assign result_byte    = obyte_reg;
    assign result_present = opres_reg;
    assign patched        = opatch_reg;

endmodule

/* sv/ips_patch_loader_and_byte_patcher.sv */
// ips patch loader and byte patcher
//
// req channel: one word per item. operation 0 feeds the next byte of an ips
// patch file, 1 looks up one byte of the patched image, 2 rewinds the search
// cursor to the first record, 3 is ignored.
// rsp channel: exactly one word per item with status, result_byte,
// result_present and patched.
//
// one item at a time. loads, rewinds and ignored items pass through the accept,
// execute and hand-off states, and the next word is taken after the hand-off.
// a read also visits the table entries from the cursor after execute (one
// entry per cycle, limited by the registered read port of the record table,
// none with no entry left), plus a byte store read step when the hit comes
// from a data record.
//
// reset clears the parser, record count, store pointer and cursor; the record
// table and byte store are not cleared, only committed entries are read.
// the result sits in an output register: when rsp stalls, a finished result
// waits there and the next item is still accepted and worked on; only the
// following hand-off waits for the register to drain.
module ips_patch_loader_and_byte_patcher #(
    parameter int MAX_RECORDS = ipspb_pkg::MAX_RECORDS_DEF,
    parameter int DATA_BYTES  = ipspb_pkg::DATA_BYTES_DEF
) (
    input logic clk,
    input logic rst_n,
    ipspb_in_if.sink    req,
    ipspb_out_if.source rsp
);

    // command and status between sequencer and datapath
    ipspb_pkg::cmd_t  cmd;
    ipspb_pkg::stat_t stat;

    // sequencer: accept, execute, scan, store read, hand-off
    ipspb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // parser, record table, byte store, search and result registers
    ipspb_dp #(
        .MAX_RECORDS (MAX_RECORDS),
        .DATA_BYTES  (DATA_BYTES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .operation        (req.operation),
        .patch_byte       (req.patch_byte),
        .read_address     (req.read_address),
        .original_byte    (req.original_byte),
        .original_present (req.original_present),
        .status           (rsp.status),
        .result_byte      (rsp.result_byte),
        .result_present   (rsp.result_present),
        .patched          (rsp.patched)
    );

endmodule

/* sv/ipspb_checker.sv */
module ipspb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [2:0] status,
    input logic [7:0] result_byte,
    input logic       result_present,
    input logic       patched
);

    // stalled word stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp word dropped while stalled");

    // stalled word holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable({status, result_byte, result_present, patched}))
        else $error("rsp payload changed while stalled");

    // one item in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second item taken while busy");

    // a patched byte is always a present byte
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && patched |-> result_present)
        else $error("patched without result");

    // non-ok status only comes from load or ignored items, which carry no byte
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ipspb_pkg::ST_OK) |-> !result_present && !patched
            && (result_byte == 8'd0))
        else $error("byte returned with non-ok status");

endmodule

bind ips_patch_loader_and_byte_patcher ipspb_checker u_ipspb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .status         (rsp.status),
    .result_byte    (rsp.result_byte),
    .result_present (rsp.result_present),
    .patched        (rsp.patched)
);
